FILE: sv/binomial_gaussian_nxn_filter_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the binomial Gaussian filter
// Shared property forms, clocked on clk and held off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef BINOMIAL_GAUSSIAN_NXN_FILTER_TOP_ASSERT_SVH
`define BINOMIAL_GAUSSIAN_NXN_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define BGNF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BGNF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/bgnf_pkg.sv
// ---------------------------------------------------------------------------
// bgnf_pkg
// Types and constants of the binomial Gaussian N x N filter.
// ---------------------------------------------------------------------------
`default_nettype none

package bgnf_pkg;

	// window rows held in line storage (kernel_size is 3 bits wide)
	localparam int MAX_KERNEL = 7;
	localparam int RMOD_W     = 3;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	localparam logic [1:0] REG_KERNEL_SIZE  = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

	typedef logic [4:0] coef_t;

	// binomial row C(n-1,k), indexed [n][k]
	localparam coef_t COEF [8][7] = '{
		'{5'd0, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
		'{5'd1, 5'd1, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
		'{5'd1, 5'd2, 5'd1,  5'd0,  5'd0,  5'd0, 5'd0},
		'{5'd1, 5'd3, 5'd3,  5'd1,  5'd0,  5'd0, 5'd0},
		'{5'd1, 5'd4, 5'd6,  5'd4,  5'd1,  5'd0, 5'd0},
		'{5'd1, 5'd5, 5'd10, 5'd10, 5'd5,  5'd1, 5'd0},
		'{5'd1, 5'd6, 5'd15, 5'd20, 5'd15, 5'd6, 5'd1}
	};

	typedef struct packed {
		logic       func;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [9:0] out_col;
		logic [9:0] out_row;
		logic       frame_end;
	} out_item_t;

endpackage

`default_nettype wire

FILE: sv/binomial_gaussian_nxn_filter_top.sv
// ---------------------------------------------------------------------------
// binomial_gaussian_nxn_filter_top
// Streaming N x N binomial blur of an RGB raster with line storage.
// ---------------------------------------------------------------------------
//  channel   signals                         moves
//  in        in_valid / in_ready / in_data   pixel or drain request
//  out       out_valid / out_ready / out_data filtered pixel with position
//  cfg       cfg_write / cfg_index / cfg_data register write, no wait
//
//  One request per clock while in_ready is high; the result of a request
//  is offered after the line store read, column sum, row sum, then the
//  rounding/output register. Each pixel is output lag*W+lag requests later,
//  lag = N-1-N/2; drain requests flush the rest of the frame. Reset clears
//  control state only; line storage has no reset. in_ready drops only while
//  out_data is held.
// ---------------------------------------------------------------------------
`default_nettype none

module binomial_gaussian_nxn_filter_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  bgnf_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output bgnf_pkg::out_item_t out_data,
	input  wire                 cfg_write,
	input  wire  [1:0]          cfg_index,
	input  wire  [10:0]         cfg_data
);

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int WCW = AW + 1;
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int HCW = RW + 1;
	localparam int DW  = $clog2(3 * MAX_WIDTH + 4);
	localparam int KR  = bgnf_pkg::MAX_KERNEL;
	localparam int RMW = bgnf_pkg::RMOD_W;

	// configuration
	logic [2:0]  kern_q;
	logic [10:0] wid_q, hgt_q;

	logic [2:0]     n_eff;
	logic [WCW-1:0] w_eff;
	logic [HCW-1:0] h_eff;
	logic [1:0]     off, lag;
	logic [3:0]     sh;
	logic [DW-1:0]  delay;

	always_comb begin
		n_eff = (kern_q < 3'd2) ? 3'd2 : kern_q;
		if (wid_q == 11'd0)
			w_eff = WCW'(1);
		else if (int'(wid_q) > MAX_WIDTH)
			w_eff = WCW'(MAX_WIDTH);
		else
			w_eff = WCW'(wid_q);
		if (hgt_q == 11'd0)
			h_eff = HCW'(1);
		else if (int'(hgt_q) > MAX_HEIGHT)
			h_eff = HCW'(MAX_HEIGHT);
		else
			h_eff = HCW'(hgt_q);
		off   = n_eff[2:1];
		lag   = 2'(n_eff - 3'd1 - {1'b0, n_eff[2:1]});
		sh    = {n_eff, 1'b0} - 4'd2;
		delay = DW'(w_eff) * DW'(lag) + DW'(lag);
	end

	// frame position state
	logic [AW-1:0]  in_col_q, em_col_q;
	logic [RW-1:0]  in_row_q, em_row_q;
	logic [RMW-1:0] in_rmod_q, em_rmod_q;
	logic [DW-1:0]  cnt_q;
	logic           drain_q;

	logic adv1, adv2, adv3, adv4;
	logic v1_s1, v2_s2, v3_s3;

	logic           acc, is_pix, restart, emit_pix, enter, interior, last_out, last_in;
	logic [AW-1:0]  ic, ec, ic_nx, ec_nx;
	logic [RW-1:0]  ir, er, ir_nx, er_nx;
	logic [RMW-1:0] irm, erm, irm_nx, erm_nx;
	logic [DW-1:0]  cnt_c;
	logic [23:0]    px_in;

	always_comb begin
		acc     = in_valid && in_ready;
		is_pix  = (in_data.func == bgnf_pkg::FUNC_PIXEL);
		restart = is_pix && (drain_q || (HCW'(in_row_q) >= h_eff)
			|| (WCW'(in_col_q) >= w_eff));
		ic    = restart ? '0 : in_col_q;
		ir    = restart ? '0 : in_row_q;
		irm   = restart ? '0 : in_rmod_q;
		ec    = restart ? '0 : em_col_q;
		er    = restart ? '0 : em_row_q;
		erm   = restart ? '0 : em_rmod_q;
		cnt_c = restart ? '0 : cnt_q;
		emit_pix = (cnt_c == delay);
		enter    = is_pix || drain_q;
		px_in    = {in_data.in_red, in_data.in_green, in_data.in_blue};

		interior = (er >= RW'(off)) && ((HCW'(er) + HCW'(off)) < h_eff)
			&& (ec >= AW'(off)) && ((WCW'(ec) + WCW'(off)) < w_eff);
		last_out = (HCW'(er) == h_eff - HCW'(1)) && (WCW'(ec) == w_eff - WCW'(1));
		last_in  = (HCW'(ir) == h_eff - HCW'(1)) && (WCW'(ic) == w_eff - WCW'(1));

		// output position advance
		ec_nx = ec + AW'(1); er_nx = er; erm_nx = erm;
		if (last_out) begin
			ec_nx = '0; er_nx = '0; erm_nx = '0;
		end else if ((WCW'(ec) + WCW'(1)) >= w_eff) begin
			ec_nx  = '0;
			er_nx  = er + RW'(1);
			erm_nx = (erm == RMW'(KR - 1)) ? '0 : erm + RMW'(1);
		end
		// input position advance
		ic_nx = ic + AW'(1); ir_nx = ir; irm_nx = irm;
		if (last_in) begin
			ic_nx = '0; ir_nx = '0; irm_nx = '0;
		end else if ((WCW'(ic) + WCW'(1)) >= w_eff) begin
			ic_nx  = '0;
			ir_nx  = ir + RW'(1);
			irm_nx = (irm == RMW'(KR - 1)) ? '0 : irm + RMW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_q    <= 3'd3;
			wid_q     <= 11'd640;
			hgt_q     <= 11'd480;
			in_col_q  <= '0; in_row_q <= '0; in_rmod_q <= '0;
			em_col_q  <= '0; em_row_q <= '0; em_rmod_q <= '0;
			cnt_q     <= '0;
			drain_q   <= 1'b0;
		end else if (cfg_write && (cfg_index == bgnf_pkg::REG_KERNEL_SIZE
				|| cfg_index == bgnf_pkg::REG_IMAGE_WIDTH
				|| cfg_index == bgnf_pkg::REG_IMAGE_HEIGHT)) begin
			case (cfg_index)
				bgnf_pkg::REG_KERNEL_SIZE:  kern_q <= cfg_data[2:0];
				bgnf_pkg::REG_IMAGE_WIDTH:  wid_q  <= cfg_data;
				bgnf_pkg::REG_IMAGE_HEIGHT: hgt_q  <= cfg_data;
				default: ;
			endcase
			// any write to a defined register restarts the frame
			in_col_q  <= '0; in_row_q <= '0; in_rmod_q <= '0;
			em_col_q  <= '0; em_row_q <= '0; em_rmod_q <= '0;
			cnt_q     <= '0;
			drain_q   <= 1'b0;
		end else if (acc) begin
			if (is_pix) begin
				in_col_q  <= ic_nx; in_row_q <= ir_nx; in_rmod_q <= irm_nx;
				cnt_q     <= last_in ? '0 : (emit_pix ? cnt_c : cnt_c + DW'(1));
				em_col_q  <= emit_pix ? ec_nx : ec;
				em_row_q  <= emit_pix ? er_nx : er;
				em_rmod_q <= emit_pix ? erm_nx : erm;
				drain_q   <= last_in && !(emit_pix && last_out);
			end else if (drain_q) begin
				em_col_q  <= ec_nx; em_row_q <= er_nx; em_rmod_q <= erm_nx;
				if (last_out)
					drain_q <= 1'b0;
			end
		end
	end

	// stage 1: line store access
	logic [23:0]    col_rd_s1 [KR];
	logic [23:0]    ctr_rd_s1 [KR];
	logic [23:0]    pix_s1;
	logic           ispix_s1, emit_s1, inter_s1, fend_s1, byp_s1;
	logic [9:0]     col_s1, row_s1;
	logic [RMW-1:0] irm_s1, erm_s1;

	for (genvar b = 0; b < KR; b++) begin : g_bank
		logic [23:0] mem [MAX_WIDTH];
		always_ff @(posedge clk) begin
			if (acc && is_pix && irm == RMW'(b))
				mem[ic] <= px_in;
			if (adv1) begin
				col_rd_s1[b] <= mem[ic];
				ctr_rd_s1[b] <= mem[ec];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v1_s1 <= 1'b0;
		else if (adv1)
			v1_s1 <= acc && enter;
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			pix_s1   <= px_in;
			ispix_s1 <= is_pix;
			emit_s1  <= is_pix ? emit_pix : 1'b1;
			inter_s1 <= interior;
			fend_s1  <= last_out;
			byp_s1   <= (delay == '0);
			col_s1   <= 10'(ec);
			row_s1   <= 10'(er);
			irm_s1   <= irm;
			erm_s1   <= erm;
		end
	end

	// stage 2: vertical weighted sum, column sums shift in
	logic [13:0]    vs_r, vs_g, vs_b;
	logic [RMW-1:0] bk;
	logic [23:0]    tap;
	logic [23:0]    ctr_s2;
	logic           emit_s2, inter_s2, fend_s2;
	logic [9:0]     col_s2, row_s2;
	logic [13:0]    cs_r [KR];
	logic [13:0]    cs_g [KR];
	logic [13:0]    cs_b [KR];

	// only the N rows of the window are summed; rows past it may be unwritten
	always_comb begin
		vs_r = '0; vs_g = '0; vs_b = '0;
		bk = '0; tap = '0;
		for (int d = 0; d < KR; d++) begin
			if (d < int'(n_eff)) begin
				bk = (irm_s1 >= RMW'(d)) ? irm_s1 - RMW'(d) : irm_s1 + RMW'(KR - d);
				tap = (d == 0) ? pix_s1 : col_rd_s1[bk];
				vs_r = vs_r + 14'(tap[23:16]) * 14'(bgnf_pkg::COEF[n_eff][d]);
				vs_g = vs_g + 14'(tap[15:8])  * 14'(bgnf_pkg::COEF[n_eff][d]);
				vs_b = vs_b + 14'(tap[7:0])   * 14'(bgnf_pkg::COEF[n_eff][d]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v2_s2 <= 1'b0;
		else if (adv2)
			v2_s2 <= v1_s1;
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			ctr_s2   <= byp_s1 ? pix_s1 : ctr_rd_s1[erm_s1];
			emit_s2  <= emit_s1;
			inter_s2 <= inter_s1;
			fend_s2  <= fend_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			if (v1_s1 && ispix_s1) begin
				cs_r[0] <= vs_r; cs_g[0] <= vs_g; cs_b[0] <= vs_b;
				for (int k = 1; k < KR; k++) begin
					cs_r[k] <= cs_r[k-1]; cs_g[k] <= cs_g[k-1]; cs_b[k] <= cs_b[k-1];
				end
			end
		end
	end

	// stage 3: horizontal weighted sum over the N newest columns
	logic [19:0] hs_r, hs_g, hs_b;
	logic [19:0] sum_r_s3, sum_g_s3, sum_b_s3;
	logic [23:0] ctr_s3;
	logic        emit_s3, inter_s3, fend_s3;
	logic [9:0]  col_s3, row_s3;

	always_comb begin
		hs_r = '0; hs_g = '0; hs_b = '0;
		for (int k = 0; k < KR; k++) begin
			if (k < int'(n_eff)) begin
				hs_r = hs_r + 20'(cs_r[k]) * 20'(bgnf_pkg::COEF[n_eff][k]);
				hs_g = hs_g + 20'(cs_g[k]) * 20'(bgnf_pkg::COEF[n_eff][k]);
				hs_b = hs_b + 20'(cs_b[k]) * 20'(bgnf_pkg::COEF[n_eff][k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v3_s3 <= 1'b0;
		else if (adv3)
			v3_s3 <= v2_s2;
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			sum_r_s3 <= hs_r; sum_g_s3 <= hs_g; sum_b_s3 <= hs_b;
			ctr_s3   <= ctr_s2;
			emit_s3  <= emit_s2;
			inter_s3 <= inter_s2;
			fend_s3  <= fend_s2;
			col_s3   <= col_s2;
			row_s3   <= row_s2;
		end
	end

	// stage 4: round half up, pick filtered or passed pixel
	logic [20:0] half;
	logic [20:0] rr, rg, rb;
	logic        out_valid_q;
	bgnf_pkg::out_item_t out_q;

	always_comb begin
		half = 21'd1 << (sh - 4'd1);
		rr   = (21'(sum_r_s3) + half) >> sh;
		rg   = (21'(sum_g_s3) + half) >> sh;
		rb   = (21'(sum_b_s3) + half) >> sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv4)
			out_valid_q <= v3_s3 && emit_s3;
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			out_q.out_red   <= inter_s3 ? rr[7:0] : ctr_s3[23:16];
			out_q.out_green <= inter_s3 ? rg[7:0] : ctr_s3[15:8];
			out_q.out_blue  <= inter_s3 ? rb[7:0] : ctr_s3[7:0];
			out_q.out_col   <= col_s3;
			out_q.out_row   <= row_s3;
			out_q.frame_end <= fend_s3;
		end
	end

	// stall chain: a stage moves when it is empty or the next one moves
	always_comb begin
		adv4 = !out_valid_q || out_ready;
		adv3 = !v3_s3 || adv4;
		adv2 = !v2_s2 || adv3;
		adv1 = !v1_s1 || adv2;
	end

	assign in_ready  = adv1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: sv/bgnf_checker.sv
// ---------------------------------------------------------------------------
// bgnf_checker
// Port-level checks of the binomial Gaussian filter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "binomial_gaussian_nxn_filter_top_assert.svh"

module bgnf_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_ready,
	input wire                 out_valid,
	input wire                 out_ready,
	input bgnf_pkg::out_item_t out_data
);

	`BGNF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
	`BGNF_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed")
	`BGNF_ASSERT_IMP(a_no_stall, out_ready, in_ready, "request refused with sink ready")
	`BGNF_ASSERT_IMP(a_stall_why, !in_ready, out_valid && !out_ready, "stall without held result")

endmodule

bind binomial_gaussian_nxn_filter_top bgnf_checker u_bgnf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

`default_nettype wire
